[src/tmu_pkg.sv]
// shared types, codes, constants and restore tables for the timer unit
// no dependencies
package tmu_pkg;

    localparam int MAIN_CHANNELS_DEF = 3;
    localparam int EXT_CHANNELS_DEF = 6;
    localparam int MATCH_STEPS_DEF = 28;
    localparam int TICK_W = 9;

    localparam logic [15:0] CM_ENABLE = 16'h0020;
    localparam logic [15:0] CM_OVF = 16'h4000;
    localparam logic [15:0] CM_MATCH = 16'h8000;
    localparam logic [15:0] CM_PERIODIC = 16'h0100;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } tmu_action_t;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_RELOAD = 2'd1,
        KIND_COUNT  = 2'd2,
        KIND_CTRL   = 2'd3
    } tmu_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAN,
        ST_MATCH,
        ST_ACCESS,
        ST_FIN
    } tmu_seq_t;

    typedef struct packed {
        logic        step;
        logic        wr;
        logic [1:0]  kind;
        logic [31:0] wdata;
    } tmu_match_ctrl_t;

    typedef struct packed {
        logic stepped;
        logic underflow;
        logic bad_presc;
    } tmu_step_res_t;

    localparam logic [31:0] MAIN_RST_CNT [8] = '{32'hffffffff, 32'h0002d000, 32'h0,
        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
    localparam logic [31:0] MAIN_RST_COR [8] = '{32'hffffffff, 32'h0002d000, 32'hffffffff,
        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
    localparam logic [15:0] MAIN_RST_CTL [8] = '{16'h0000, 16'h0023, 16'h0003,
        16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
    localparam logic [31:0] EXT_RST_CNT [8] = '{32'h333, 32'h333, 32'h333, 32'h333,
        32'h333, 32'hf8a58232, 32'h333, 32'h333};
    localparam logic [31:0] EXT_RST_COR [8] = '{32'h333, 32'h333, 32'h333, 32'h333,
        32'h333, 32'hffffffff, 32'h333, 32'h333};
    localparam logic EXT_RST_RUN [8] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    function automatic logic [31:0] rst_counter(input int i, input int nmain);
        logic [31:0] r;
        if (i < nmain)
            r = MAIN_RST_CNT[i % 8];
        else
            r = EXT_RST_CNT[(i - nmain) % 8];
        return r;
    endfunction

    function automatic logic [31:0] rst_reload(input int i, input int nmain);
        logic [31:0] r;
        if (i < nmain)
            r = MAIN_RST_COR[i % 8];
        else
            r = EXT_RST_COR[(i - nmain) % 8];
        return r;
    endfunction

    function automatic logic [15:0] rst_control(input int i, input int nmain);
        logic [15:0] r;
        if (i < nmain)
            r = MAIN_RST_CTL[i % 8];
        else
            r = 16'h0;
        return r;
    endfunction

    function automatic logic rst_started(input int i, input int nmain);
        logic r;
        if (i < nmain)
            r = 1'b0;
        else
            r = EXT_RST_RUN[(i - nmain) % 8];
        return r;
    endfunction

endpackage

[src/tmu_if.sv]
// request and response channel interfaces of the timer unit
// depends on tmu_pkg
interface tmu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  reg_channel;
    logic [1:0]  reg_kind;
    logic [31:0] write_value;

    modport source (output valid, action, reg_channel, reg_kind, write_value, input ready);
    modport sink (input valid, action, reg_channel, reg_kind, write_value, output ready);
endinterface

interface tmu_rsp_if #(parameter int NCH = tmu_pkg::MAIN_CHANNELS_DEF + tmu_pkg::EXT_CHANNELS_DEF);
    logic           valid;
    logic           ready;
    logic [31:0]    read_data;
    logic [NCH-1:0] underflow_mask;
    logic           prescaler_error;

    modport source (output valid, read_data, underflow_mask, prescaler_error, input ready);
    modport sink (input valid, read_data, underflow_mask, prescaler_error, output ready);
endinterface

[src/tmu_chan_step.sv]
// shared channel step unit: prescaler test, underflow and reload, decrement
// depends on tmu_pkg
module tmu_chan_step (
    input  logic                    started,
    input  logic                    is_main,
    input  logic [2:0]              presc,
    input  logic [tmu_pkg::TICK_W-1:0] tick,
    input  logic [31:0]             counter,
    input  logic [31:0]             reload,
    output logic [31:0]             counter_next,
    output tmu_pkg::tmu_step_res_t  res
);
    import tmu_pkg::*;

    logic [11:0]       period;
    logic [TICK_W-1:0] tick_mask;
    logic              due;
    logic              bad;
    logic              zero;
    logic [31:0]       base;

    always_comb
    begin
        period = 12'd8 << {presc[1:0], 1'b0};
        tick_mask = period[TICK_W-1:0] - TICK_W'(1);
        bad = is_main && presc[2];
        due = !is_main || ((tick & tick_mask) == '0);
        zero = (counter == 32'h0);
        base = zero ? reload : counter;
        res.stepped = started && !bad && due;
        res.underflow = started && !bad && due && zero;
        res.bad_presc = started && bad;
        counter_next = base - 32'd1;
    end
endmodule

[src/tmu_match_unit.sv]
// compare-match timer: registers and one increment sub-step per cycle
// depends on tmu_pkg
module tmu_match_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tmu_pkg::tmu_match_ctrl_t ctrl,
    output logic [31:0]              rdata
);
    import tmu_pkg::*;

    logic [15:0] start_reg;
    logic [15:0] status_reg;
    logic [31:0] count_reg;
    logic [31:0] const_reg;
    logic [31:0] inc;

    assign inc = count_reg + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            status_reg <= '0;
            count_reg <= '0;
            const_reg <= '0;
        end
        else if (ctrl.wr)
        begin
            unique case (tmu_kind_t'(ctrl.kind))
                KIND_START:  start_reg <= ctrl.wdata[15:0];
                KIND_RELOAD: const_reg <= ctrl.wdata;
                KIND_COUNT:  count_reg <= ctrl.wdata;
                KIND_CTRL:   status_reg <= ctrl.wdata[15:0];
                default:     status_reg <= status_reg;
            endcase
        end
        else if (ctrl.step && ((start_reg & CM_ENABLE) != '0))
        begin
            if (inc == const_reg)
            begin
                count_reg <= '0;
                if ((start_reg & CM_PERIODIC) == '0)
                    start_reg <= start_reg & ~CM_ENABLE;
            end
            else
                count_reg <= inc;
            status_reg <= status_reg | ((inc == 32'hffffffff) ? CM_OVF : 16'h0)
                | ((inc == const_reg) ? CM_MATCH : 16'h0);
        end
    end

    always_comb
    begin
        unique case (tmu_kind_t'(ctrl.kind))
            KIND_START:  rdata = {16'h0, start_reg};
            KIND_RELOAD: rdata = const_reg;
            KIND_COUNT:  rdata = count_reg;
            KIND_CTRL:   rdata = {16'h0, status_reg};
            default:     rdata = '0;
        endcase
    end
endmodule

[src/reload_timer_unit_with_compare_match.sv]
// top level of the reload timer unit with compare-match counter
// depends on tmu_pkg, tmu_if, tmu_chan_step, tmu_match_unit
//
// A tick word visits each timer channel in turn through one step unit and
// then runs the compare-match increment sub-steps one per cycle. A
// register read or write passes through the access state and then the
// finish state; other actions go straight to the finish state. One word is
// worked on at a time; the result sits in an output register so the next
// word can be taken while it waits.
module reload_timer_unit_with_compare_match #(
    parameter int MAIN_CHANNELS = tmu_pkg::MAIN_CHANNELS_DEF,
    parameter int EXT_CHANNELS = tmu_pkg::EXT_CHANNELS_DEF,
    parameter int MATCH_STEPS_PER_TICK = tmu_pkg::MATCH_STEPS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tmu_req_if.sink   req,
    tmu_rsp_if.source rsp
);
    import tmu_pkg::*;

    localparam int NCH = MAIN_CHANNELS + EXT_CHANNELS;
    localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SW = (MATCH_STEPS_PER_TICK > 1) ? $clog2(MATCH_STEPS_PER_TICK) : 1;

    tmu_seq_t state_reg, state_next;

    logic [31:0]       cnt_reg [NCH];
    logic [31:0]       cor_reg [NCH];
    logic [15:0]       ctl_reg [NCH];
    logic [NCH-1:0]    run_reg;
    logic [TICK_W-1:0] tick_reg;

    logic [CW-1:0] idx_reg;
    logic [SW-1:0] step_reg;
    logic [1:0]    act_reg;
    logic [3:0]    chan_reg;
    logic [1:0]    kind_reg;
    logic [31:0]   wval_reg;

    logic [NCH-1:0] umask_acc_reg;
    logic           err_acc_reg;
    logic [31:0]    rdata_acc_reg;

    logic           out_valid_reg;
    logic [31:0]    out_rdata_reg;
    logic [NCH-1:0] out_umask_reg;
    logic           out_err_reg;

    logic [CW-1:0]   sel_idx;
    logic            chan_ok;
    logic            match_sel;
    logic [31:0]     cnt_next;
    tmu_step_res_t   sres;
    tmu_match_ctrl_t mctrl;
    logic [31:0]     m_rdata;
    logic            last_chan;
    logic            last_step;
    logic            out_free;
    logic            in_ready;
    logic [31:0]     chan_rdata;

    assign chan_ok = ({1'b0, chan_reg} < 5'(NCH));
    assign match_sel = ({1'b0, chan_reg} == 5'(NCH));
    assign sel_idx = (state_reg == ST_CHAN) ? idx_reg : chan_reg[CW-1:0];
    assign last_chan = (idx_reg == CW'(NCH - 1));
    assign last_step = (step_reg == SW'(MATCH_STEPS_PER_TICK - 1));
    assign out_free = !out_valid_reg || rsp.ready;

    tmu_chan_step u_step (
        .started      (run_reg[sel_idx]),
        .is_main      ({1'b0, sel_idx} < (CW + 1)'(MAIN_CHANNELS)),
        .presc        (ctl_reg[sel_idx][2:0]),
        .tick         (tick_reg),
        .counter      (cnt_reg[sel_idx]),
        .reload       (cor_reg[sel_idx]),
        .counter_next (cnt_next),
        .res          (sres)
    );

    tmu_match_unit u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mctrl),
        .rdata (m_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (tmu_action_t'(req.action))
                        ACT_TICK:  state_next = ST_CHAN;
                        ACT_WRITE: state_next = ST_ACCESS;
                        ACT_READ:  state_next = ST_ACCESS;
                        default:   state_next = ST_FIN;
                    endcase
                end
            end
            ST_CHAN:   state_next = last_chan ? ST_MATCH : ST_CHAN;
            ST_MATCH:  state_next = last_step ? ST_FIN : ST_MATCH;
            ST_ACCESS: state_next = ST_FIN;
            ST_FIN:    state_next = out_free ? ST_IDLE : ST_FIN;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        mctrl.step = (state_reg == ST_MATCH);
        mctrl.wr = (state_reg == ST_ACCESS) && (act_reg == ACT_WRITE) && match_sel;
        mctrl.kind = kind_reg;
        mctrl.wdata = wval_reg;
    end

    assign req.ready = in_ready;

    always_comb
    begin
        unique case (tmu_kind_t'(kind_reg))
            KIND_START:  chan_rdata = {31'h0, run_reg[sel_idx]};
            KIND_RELOAD: chan_rdata = cor_reg[sel_idx];
            KIND_COUNT:  chan_rdata = cnt_reg[sel_idx];
            KIND_CTRL:   chan_rdata = {16'h0, ctl_reg[sel_idx]};
            default:     chan_rdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg <= '0;
            idx_reg <= '0;
            step_reg <= '0;
            act_reg <= ACT_NONE;
            chan_reg <= '0;
            kind_reg <= '0;
            wval_reg <= '0;
            umask_acc_reg <= '0;
            err_acc_reg <= 1'b0;
            rdata_acc_reg <= '0;
            out_valid_reg <= 1'b0;
            out_rdata_reg <= '0;
            out_umask_reg <= '0;
            out_err_reg <= 1'b0;
            for (int i = 0; i < NCH; i++)
            begin
                cnt_reg[i] <= rst_counter(i, MAIN_CHANNELS);
                cor_reg[i] <= rst_reload(i, MAIN_CHANNELS);
                ctl_reg[i] <= rst_control(i, MAIN_CHANNELS);
                run_reg[i] <= rst_started(i, MAIN_CHANNELS);
            end
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        act_reg <= req.action;
                        chan_reg <= req.reg_channel;
                        kind_reg <= req.reg_kind;
                        wval_reg <= req.write_value;
                        idx_reg <= '0;
                        step_reg <= '0;
                        umask_acc_reg <= '0;
                        err_acc_reg <= 1'b0;
                        rdata_acc_reg <= '0;
                    end
                end
                ST_CHAN:
                begin
                    if (sres.stepped)
                        cnt_reg[sel_idx] <= cnt_next;
                    if (sres.underflow)
                        umask_acc_reg[sel_idx] <= 1'b1;
                    if (sres.bad_presc)
                        err_acc_reg <= 1'b1;
                    idx_reg <= idx_reg + CW'(1);
                end
                ST_MATCH:
                begin
                    step_reg <= step_reg + SW'(1);
                    if (last_step)
                        tick_reg <= tick_reg + TICK_W'(1);
                end
                ST_ACCESS:
                begin
                    if (act_reg == ACT_READ)
                        rdata_acc_reg <= chan_ok ? chan_rdata : (match_sel ? m_rdata : 32'h0);
                    if ((act_reg == ACT_WRITE) && chan_ok)
                    begin
                        unique case (tmu_kind_t'(kind_reg))
                            KIND_START:  run_reg[sel_idx] <= wval_reg[0];
                            KIND_RELOAD: cor_reg[sel_idx] <= wval_reg;
                            KIND_COUNT:  cnt_reg[sel_idx] <= wval_reg;
                            KIND_CTRL:
                                ctl_reg[sel_idx] <= ({1'b0, sel_idx} < (CW + 1)'(MAIN_CHANNELS))
                                    ? wval_reg[15:0] : {8'h0, wval_reg[7:0]};
                            default:     run_reg <= run_reg;
                        endcase
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_rdata_reg <= rdata_acc_reg;
                        out_umask_reg <= umask_acc_reg;
                        out_err_reg <= err_acc_reg;
                    end
                end
                default:
                begin
                    idx_reg <= '0;
                end
            endcase
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.read_data = out_rdata_reg;
    assign rsp.underflow_mask = out_umask_reg;
    assign rsp.prescaler_error = out_err_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while a word is in progress");

    a_chan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHAN) |-> ({1'b0, idx_reg} < (CW + 1)'(NCH)))
        else $error("channel sweep ran past the last channel");

    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_reg != $past(tick_reg)) |-> ($past(state_reg) == ST_MATCH))
        else $error("tick count moved outside a tick");
`endif
endmodule

[tb/tmu_tb_checker.sv]
// timer unit checker: watches the request and response channels, predicts each result word
// depends on tmu_pkg and tmu_if
`timescale 1ns / 1ps
module tmu_tb_checker (
    input  logic      clk,
    input  logic      rst_n,
    tmu_req_if        req,
    tmu_rsp_if        rsp,
    output int        fail_count,
    output int        pending
);
    import tmu_pkg::*;

    localparam int NMAIN = MAIN_CHANNELS_DEF;
    localparam int NCHAN = MAIN_CHANNELS_DEF + EXT_CHANNELS_DEF;
    localparam int MATCH_STEPS = MATCH_STEPS_DEF;

    typedef struct packed {
        logic [31:0]      data;
        logic [NCHAN-1:0] uflow;
        logic             perr;
    } tmu_result_t;

    logic [31:0] cnt [NCHAN];
    logic [31:0] rel [NCHAN];
    logic [15:0] ctl [NCHAN];
    logic        run [NCHAN];
    logic [8:0]  ticks;
    logic [15:0] cm_start, cm_status;
    logic [31:0] cm_count, cm_const;

    tmu_result_t expected_results[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic tmu_result_t timer_tick();
        tmu_result_t r;
        logic [31:0] period;
        r = '0;
        for (int i = 0; i < NCHAN; i++)
        begin
            if (!run[i])
                continue;
            if (i < NMAIN)
            begin
                if (ctl[i][2:0] >= 3'd4)
                begin
                    r.perr = 1'b1;
                    continue;
                end
                period = 32'd8 << (2 * ctl[i][1:0]);
                if ((32'(ticks) & (period - 1)) != 0)
                    continue;
            end
            if (cnt[i] == 0)
            begin
                r.uflow[i] = 1'b1;
                cnt[i] = rel[i];
            end
            cnt[i] = cnt[i] - 1;
        end
        for (int s = 0; s < MATCH_STEPS; s++)
        begin
            if ((cm_start & CM_ENABLE) == 0)
                continue;
            cm_count = cm_count + 1;
            if (cm_count == 32'hffffffff)
                cm_status |= CM_OVF;
            if (cm_count == cm_const)
            begin
                cm_status |= CM_MATCH;
                cm_count = 0;
                if ((cm_start & CM_PERIODIC) == 0)
                    cm_start &= ~CM_ENABLE;
            end
        end
        ticks = ticks + 1;
        return r;
    endfunction

    function automatic void register_write(input int ch, input tmu_kind_t k, input logic [31:0] v);
        if (ch < NCHAN)
        begin
            case (k)
                KIND_START:  run[ch] = v[0];
                KIND_RELOAD: rel[ch] = v;
                KIND_COUNT:  cnt[ch] = v;
                default:     ctl[ch] = (ch < NMAIN) ? v[15:0] : {8'h0, v[7:0]};
            endcase
        end
        else if (ch == NCHAN)
        begin
            case (k)
                KIND_START:  cm_start = v[15:0];
                KIND_RELOAD: cm_const = v;
                KIND_COUNT:  cm_count = v;
                default:     cm_status = v[15:0];
            endcase
        end
    endfunction

    function automatic logic [31:0] register_read(input int ch, input tmu_kind_t k);
        if (ch < NCHAN)
        begin
            case (k)
                KIND_START:  return {31'h0, run[ch]};
                KIND_RELOAD: return rel[ch];
                KIND_COUNT:  return cnt[ch];
                default:     return {16'h0, ctl[ch]};
            endcase
        end
        if (ch == NCHAN)
        begin
            case (k)
                KIND_START:  return {16'h0, cm_start};
                KIND_RELOAD: return cm_const;
                KIND_COUNT:  return cm_count;
                default:     return {16'h0, cm_status};
            endcase
        end
        return 32'h0;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        tmu_result_t r, w;
        if (!rst_n)
        begin
            for (int i = 0; i < NCHAN; i++)
            begin
                cnt[i] = rst_counter(i, NMAIN);
                rel[i] = rst_reload(i, NMAIN);
                ctl[i] = rst_control(i, NMAIN);
                run[i] = rst_started(i, NMAIN);
            end
            ticks = 0;
            cm_start = 0;
            cm_status = 0;
            cm_count = 0;
            cm_const = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            // response first: the word accepted now cannot be answered in the same cycle
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                    report("unexpected word", rsp.read_data, 32'h0);
                else
                begin
                    w = expected_results.pop_front();
                    if (rsp.read_data !== w.data)
                        report("read_data", rsp.read_data, w.data);
                    if (rsp.underflow_mask !== w.uflow)
                        report("underflow_mask", 32'(rsp.underflow_mask), 32'(w.uflow));
                    if (rsp.prescaler_error !== w.perr)
                        report("prescaler_error", 32'(rsp.prescaler_error), 32'(w.perr));
                end
            end
            if (req.valid && req.ready)
            begin
                r = '0;
                case (tmu_action_t'(req.action))
                    ACT_TICK:  r = timer_tick();
                    ACT_WRITE: register_write(req.reg_channel, tmu_kind_t'(req.reg_kind),
                                              req.write_value);
                    ACT_READ:  r.data = register_read(req.reg_channel,
                                                      tmu_kind_t'(req.reg_kind));
                    default:   ;
                endcase
                expected_results.push_back(r);
            end
        end
    end

endmodule

[tb/tb_top.sv]
// timer unit testbench top: clock, reset, request stimulus, response stalls and verdict
// depends on tmu_pkg, tmu_if, tmu_tb_checker and the timer unit
`timescale 1ns / 1ps
module tb_top;
    import tmu_pkg::*;

    localparam int NCHAN = MAIN_CHANNELS_DEF + EXT_CHANNELS_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct = 0;

    tmu_req_if req ();
    tmu_rsp_if rsp ();

    reload_timer_unit_with_compare_match i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    tmu_tb_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // response stalls
    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    // one word, with random idle cycles in front; valid stays up until the next idle
    task automatic send_word(input tmu_action_t a, input int ch, input tmu_kind_t k,
                             input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= a;
        req.reg_channel <= 4'(ch);
        req.reg_kind <= k;
        req.write_value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            2:       return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_word();
        int          sel;
        int          ch;
        tmu_kind_t   k;
        logic [31:0] v;
        sel = $urandom_range(99);
        ch = $urandom_range(15);
        if ($urandom_range(3) != 0)
            ch = $urandom_range(NCHAN);
        k = tmu_kind_t'($urandom_range(3));
        v = rand_value();
        // keep prescalers mostly valid and counts small so channels underflow
        if (k == KIND_CTRL && ch < MAIN_CHANNELS_DEF && $urandom_range(3) != 0)
            v = ($urandom_range(65535) & 32'hfff8) | $urandom_range(3);
        if (k == KIND_CTRL && ch < MAIN_CHANNELS_DEF)
            v = (v & 32'hfffffff8) | (v & 7);
        if ((k == KIND_COUNT || k == KIND_RELOAD) && $urandom_range(1))
            v = $urandom_range(20);
        if (ch == NCHAN && k == KIND_COUNT && $urandom_range(2) == 0)
            v = 32'hffffffff - $urandom_range(60);
        if (sel < 50)
            send_word(ACT_TICK, ch, k, v);
        else if (sel < 75)
            send_word(ACT_WRITE, ch, k, v);
        else if (sel < 98)
            send_word(ACT_READ, ch, k, v);
        else
            send_word(ACT_NONE, ch, k, v);
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.action = ACT_TICK;
        req.reg_channel = '0;
        req.reg_kind = KIND_START;
        req.write_value = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset values, extremes, bad prescaler, unmapped channel, both flags
        for (int c = 0; c <= NCHAN; c += 3)
            send_word(ACT_READ, c, KIND_COUNT, 32'h0);
        send_word(ACT_WRITE, 0, KIND_START, 32'hffffffff);
        send_word(ACT_WRITE, 0, KIND_CTRL, 32'h0000fffc);
        send_word(ACT_WRITE, 3, KIND_CTRL, 32'hffffffff);
        send_word(ACT_WRITE, 1, KIND_START, 32'h1);
        send_word(ACT_WRITE, 1, KIND_CTRL, 32'h7);
        send_word(ACT_TICK, 0, KIND_START, 32'h0);
        send_word(ACT_WRITE, 1, KIND_CTRL, 32'h0);
        send_word(ACT_WRITE, 15, KIND_COUNT, 32'h12345678);
        send_word(ACT_READ, 15, KIND_CTRL, 32'h0);
        send_word(ACT_NONE, 5, KIND_RELOAD, 32'hffffffff);
        send_word(ACT_WRITE, NCHAN, KIND_RELOAD, 32'hffffffff);
        send_word(ACT_WRITE, NCHAN, KIND_COUNT, 32'hfffffff0);
        send_word(ACT_WRITE, NCHAN, KIND_START, 32'h0000ffff);
        send_word(ACT_TICK, 0, KIND_START, 32'h0);
        send_word(ACT_READ, NCHAN, KIND_CTRL, 32'h0);
        send_word(ACT_WRITE, NCHAN, KIND_CTRL, 32'h0);
        send_word(ACT_WRITE, NCHAN, KIND_START, 32'h0020);
        send_word(ACT_WRITE, NCHAN, KIND_RELOAD, 32'd5);
        send_word(ACT_TICK, 0, KIND_START, 32'h0);
        send_word(ACT_READ, NCHAN, KIND_START, 32'h0);
        send_word(ACT_READ, 3, KIND_CTRL, 32'h0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 83; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 83; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            repeat (325)
                random_word();
        end
        req.valid <= 1'b0;
        stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
